// File: rtl/assert_macros.svh
// assertion macros for the checker file
// no dependencies; the user provides clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on the rising edge, masked while reset is held
`define GAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on the rising edge, live during reset as well
`define GAS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/gas_pkg.sv
// shared types, constants and saturating arithmetic for the alignment scorer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gas_pkg;

  // sizes of the query row
  localparam int MaxQuery = 256;
  localparam int IdxW     = $clog2(MaxQuery);
  localparam int LenW     = IdxW + 1;
  localparam int ScoreW   = 32;
  localparam int InitW    = 17;

  // operation codes of an input beat
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MATCH    = 2'd0;
  localparam logic [1:0] CFG_MISMATCH = 2'd1;
  localparam logic [1:0] CFG_GAP      = 2'd2;

  // register reset values
  localparam logic [6:0]        MATCH_RST    = 7'd8;
  localparam logic signed [7:0] MISMATCH_RST = -8'sd5;
  localparam logic signed [7:0] GAP_RST      = -8'sd3;

  // wavefront token travelling down the cell row
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    logic [7:0]               sym;
    logic signed [ScoreW-1:0] diag;
    logic signed [ScoreW-1:0] left;
    logic signed [InitW-1:0]  init;
  } tok_t;

  // query load strobes from the controller
  typedef struct packed {
    logic            clr;
    logic            wr;
    logic [IdxW-1:0] idx;
    logic [7:0]      sym;
  } ld_t;

  // a + b clamped to the 32-bit signed range
  function automatic logic signed [ScoreW-1:0] sat_add(input logic signed [ScoreW-1:0] a,
                                                      input logic signed [7:0] b);
    logic signed [ScoreW:0] s;
    s = (ScoreW+1)'(a) + (ScoreW+1)'(b);
    if (s[ScoreW] != s[ScoreW-1]) begin
      sat_add = s[ScoreW] ? {1'b1, {(ScoreW-1){1'b0}}} : {1'b0, {(ScoreW-1){1'b1}}};
    end else begin
      sat_add = s[ScoreW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/gas_cell.sv
// one cell of the score row: holds a query symbol and its score column
// depends on gas_pkg
`timescale 1ns / 1ps
`default_nettype none

module gas_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              ld_wr,
  input  wire logic              ld_clr,
  input  wire logic [7:0]        ld_sym,
  input  wire logic [6:0]        match_score,
  input  wire logic signed [7:0] mismatch_score,
  input  wire logic signed [7:0] gap_score,
  input  wire gas_pkg::tok_t     tok_in,
  output gas_pkg::tok_t          tok_out
);

  logic                             act_r;
  logic [7:0]                       q_r;
  logic signed [gas_pkg::ScoreW-1:0] score_r;
  gas_pkg::tok_t                    tok_r;
  gas_pkg::tok_t                    tok_nxt;

  logic signed [gas_pkg::ScoreW-1:0] old_val;
  logic signed [7:0]                 add_val;
  logic signed [gas_pkg::ScoreW-1:0] d_val;
  logic signed [gas_pkg::ScoreW-1:0] u_val;
  logic signed [gas_pkg::ScoreW-1:0] l_val;
  logic signed [gas_pkg::ScoreW-1:0] m_val;

  // recurrence for this column
  always_comb begin
    old_val = tok_in.first ? gas_pkg::ScoreW'(tok_in.init) : score_r;
    add_val = (q_r == tok_in.sym) ? {1'b0, match_score} : mismatch_score;
    d_val   = gas_pkg::sat_add(tok_in.diag, add_val);
    u_val   = gas_pkg::sat_add(old_val, gap_score);
    l_val   = gas_pkg::sat_add(tok_in.left, gap_score);
    m_val   = d_val;
    if (u_val > m_val) begin
      m_val = u_val;
    end
    if (l_val > m_val) begin
      m_val = l_val;
    end
  end

  // token for the next cell; an unused cell passes the left value through
  always_comb begin
    tok_nxt      = tok_in;
    tok_nxt.init = tok_in.init + gas_pkg::InitW'(gap_score);
    if (act_r) begin
      tok_nxt.diag = old_val;
      tok_nxt.left = m_val;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  // column score
  always_ff @(posedge clk) begin
    if (adv && tok_in.valid && act_r) begin
      score_r <= m_val;
    end
  end

  // query symbol and in-use flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (ld_wr) begin
      act_r <= 1'b1;
    end else if (ld_clr) begin
      act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_wr) begin
      q_r <= ld_sym;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: rtl/gas_ctrl.sv
// input beat control: query loading, boundary column and token launch
// depends on gas_pkg
`timescale 1ns / 1ps
`default_nettype none

module gas_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              exit_vld,
  input  wire logic              cfg_valid,
  input  wire logic              in_valid,
  input  wire logic              in_operation,
  input  wire logic [7:0]        in_symbol,
  input  wire logic              in_last,
  input  wire logic signed [7:0] gap_score,
  output logic                   in_ready,
  output logic                   idle,
  output gas_pkg::ld_t           ld,
  output gas_pkg::tok_t          head_tok
);

  logic [gas_pkg::LenW-1:0]          len_r, len_nxt, len_eff;
  logic                              qdone_r, qdone_nxt;
  logic                              first_r, first_nxt;
  logic signed [gas_pkg::ScoreW-1:0] row0_r, row0_nxt, old0;
  logic [gas_pkg::LenW-1:0]          infl_r, infl_nxt;
  gas_pkg::tok_t                     head_r, head_nxt;
  logic                              acc, do_load, do_tgt, wr_ok;

  // beat acceptance; a query load waits for an empty row
  // a register beat taken on an empty row goes in before any input beat
  assign idle     = (infl_r == '0);
  assign in_ready = adv && !(cfg_valid && idle) &&
                    ((in_operation == gas_pkg::OP_TARGET) || idle);
  assign acc      = in_valid && in_ready;
  assign do_load  = acc && (in_operation == gas_pkg::OP_LOAD);
  assign do_tgt   = acc && (in_operation == gas_pkg::OP_TARGET);

  // query length bookkeeping
  always_comb begin
    len_eff   = qdone_r ? '0 : len_r;
    wr_ok     = (len_eff < gas_pkg::LenW'(gas_pkg::MaxQuery));
    len_nxt   = len_r;
    qdone_nxt = qdone_r;
    if (do_load) begin
      len_nxt   = len_eff + gas_pkg::LenW'(wr_ok);
      qdone_nxt = in_last;
    end
  end

  assign ld.clr = do_load && qdone_r;
  assign ld.wr  = do_load && wr_ok;
  assign ld.idx = len_eff[gas_pkg::IdxW-1:0];
  assign ld.sym = in_symbol;

  // boundary column and head token
  always_comb begin
    old0      = first_r ? '0 : row0_r;
    row0_nxt  = row0_r;
    first_nxt = first_r;
    head_nxt  = head_r;
    if (adv) begin
      head_nxt.valid = do_tgt;
      head_nxt.first = first_r;
      head_nxt.last  = in_last;
      head_nxt.sym   = in_symbol;
      head_nxt.diag  = old0;
      head_nxt.left  = gas_pkg::sat_add(old0, gap_score);
      head_nxt.init  = gas_pkg::InitW'(gap_score);
    end
    if (do_tgt) begin
      row0_nxt  = gas_pkg::sat_add(old0, gap_score);
      first_nxt = in_last;
    end else if (do_load) begin
      first_nxt = 1'b1;
    end
  end

  // tokens in flight between launch and leaving the last cell
  always_comb begin
    infl_nxt = infl_r + gas_pkg::LenW'(do_tgt) - gas_pkg::LenW'(exit_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      qdone_r <= 1'b0;
      first_r <= 1'b1;
      infl_r  <= '0;
      head_r  <= '0;
    end else begin
      len_r   <= len_nxt;
      qdone_r <= qdone_nxt;
      first_r <= first_nxt;
      infl_r  <= infl_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row0_r <= row0_nxt;
  end

  assign head_tok = head_r;

endmodule

`default_nettype wire

// File: rtl/global_alignment_score.sv
// top level of the linear-gap global alignment scorer: registers, cell row, result stage
// depends on gas_pkg, gas_ctrl and gas_cell
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_operation, in_symbol, in_last
//  out     | output    | out_valid/out_ready | out_score
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a target beat is taken every cycle unless a held result or a register beat stops it;
// its wavefront walks 256 cells, one per cycle while the row advances
// the score is registered in the result stage when the last target beat's token
// leaves the last cell; a query load or register write waits until the row is empty;
// a register beat on an empty row holds input beats off for that cycle
// synchronous reset; the query store has no clearing pass and needs no warm-up cycles
// a stalled result freezes the whole row and the input side together
`timescale 1ns / 1ps
`default_nettype none

module global_alignment_score (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_score,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [6:0]        match_r;
  logic signed [7:0] mismatch_r;
  logic signed [7:0] gap_r;
  logic              adv, idle, exit_vld;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_score_r;
  gas_pkg::ld_t      ld;
  gas_pkg::tok_t     chain [0:gas_pkg::MaxQuery];

  // row moves unless a finished score is held up
  assign adv      = !out_valid_r || out_ready;
  assign exit_vld = adv && chain[gas_pkg::MaxQuery].valid;

  // configuration registers
  assign cfg_ready = idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= gas_pkg::MATCH_RST;
      mismatch_r <= gas_pkg::MISMATCH_RST;
      gap_r      <= gas_pkg::GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gas_pkg::CFG_MATCH:    match_r    <= cfg_data[6:0];
        gas_pkg::CFG_MISMATCH: mismatch_r <= cfg_data;
        gas_pkg::CFG_GAP:      gap_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // beat control and boundary column
  gas_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .exit_vld     (exit_vld),
    .cfg_valid    (cfg_valid),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_symbol    (in_symbol),
    .in_last      (in_last),
    .gap_score    (gap_r),
    .in_ready     (in_ready),
    .idle         (idle),
    .ld           (ld),
    .head_tok     (chain[0])
  );

  // row of cells, one per query position
  for (genvar j = 0; j < gas_pkg::MaxQuery; j++) begin : g_cell
    gas_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .adv            (adv),
      .ld_wr          (ld.wr && (ld.idx == gas_pkg::IdxW'(j))),
      .ld_clr         (ld.clr),
      .ld_sym         (ld.sym),
      .match_score    (match_r),
      .mismatch_score (mismatch_r),
      .gap_score      (gap_r),
      .tok_in         (chain[j]),
      .tok_out        (chain[j+1])
    );
  end

  // result stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = exit_vld && chain[gas_pkg::MaxQuery].last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_score_r <= chain[gas_pkg::MaxQuery].left;
    end
  end

  assign out_valid = out_valid_r;
  assign out_score = out_score_r;

endmodule

`default_nettype wire

// File: rtl/gas_checker.sv
// port-level checks for the alignment scorer, bound to the top level
// depends on gas_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gas_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_score,
  input wire logic        cfg_ready
);

  logic load_beat;

  // query load beat taken this cycle
  assign load_beat = in_valid && in_ready && (in_operation == gas_pkg::OP_LOAD);

  // held result beat stays up
  `GAS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")

  // held result beat keeps its score
  `GAS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_score), "result changed")

  // a query load only goes in with the row empty
  `GAS_ASSERT(a_load_idle, load_beat |-> cfg_ready, "load while busy")

  // reset leaves no result pending and the row empty
  `GAS_ASSERT_RST(a_reset, !rst_n |=> !out_valid && cfg_ready, "state after reset")

endmodule

bind global_alignment_score gas_checker u_gas_checker (.*);

`default_nettype wire
